### hdl/glyph_alpha_outline_dilation_assert.svh
// Assertion macros shared by the glyph outline checker
`ifndef GLYPH_ALPHA_OUTLINE_DILATION_ASSERT_SVH
`define GLYPH_ALPHA_OUTLINE_DILATION_ASSERT_SVH

// Check on clk_i, quiet while rst_ni is low
`define GAOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on clk_i, including the reset period
`define GAOD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/gaod_pkg.sv
// Shared widths, defaults and register codes for the glyph outline block
package gaod_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 256;
  localparam int MAX_EDGE_DEF      = 8;

  localparam int ALPHA_W    = 8;
  localparam int PIXEL_W    = 32;
  localparam int EDGE_CFG_W = 4;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_SIZE = 1'b0,
    REG_ROW_WIDTH = 1'b1
  } cfg_reg_e;

endpackage

### hdl/gaod_ram.sv
// Generic single-write, single-read RAM with registered read data
module gaod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/gaod_delay.sv
// Word delay line whose length is set at run time, output at a fixed stage
module gaod_delay #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [$clog2(DEPTH+1)-1:0] len_i,
  input  logic [WIDTH-1:0]           din_i,
  output logic [WIDTH-1:0]           dout_o
);

  logic [WIDTH-1:0] stage_q [DEPTH];
  logic [WIDTH-1:0] stage_d [DEPTH];

  // Insert the new word at stage len-1 and move everything one stage towards 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    if (k == DEPTH - 1) begin : g_last
      always_comb begin
        stage_d[k] = stage_q[k];
        if (32'(len_i) == 32'(k + 1)) begin
          stage_d[k] = din_i;
        end
      end
    end else begin : g_mid
      always_comb begin
        stage_d[k] = stage_q[k+1];
        if (32'(len_i) == 32'(k + 1)) begin
          stage_d[k] = din_i;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign dout_o = (len_i == '0) ? din_i : stage_q[0];

endmodule

### hdl/glyph_alpha_outline_dilation.sv
// Top level of the glyph alpha outline dilation block
//
// Input stream: one source alpha word per padded grid position in raster
// order; tuser marks the first position of a new glyph and restarts the
// column, row and ring-slot counters for that word. Output stream: one
// 32-bit pixel per input word, top byte = outline max OR body, lower three
// bytes = body alpha (the source shifted by the edge size in x and y).
// Configuration: edge_size (index 0) and padded_row_width (index 1) through
// the write port; any write restarts the image. Write only while idle.
// Storage: a ring of 2*MAX_EDGE+1 rows in two mirrored RAMs, one read for
// the row edge_size above, one for the row 2*edge_size above, both at the
// current column; short run-time delay lines supply the column offsets.
// Pipeline: an accepted word passes the stage 1 and output registers.
// Throughput: one word per cycle unless stalled; each RAM read once per word.
// Stall: when the receiver holds tready low with a word in the output
// register, it and the stage behind it hold, and input tready drops too.
// Reset: counters clear, edge 0, row width 1, no word in flight. The RAMs
// need no clearing pass; rows not yet written in this image read as zero.
module glyph_alpha_outline_dilation #(
  parameter int MAX_ROW_WIDTH = gaod_pkg::MAX_ROW_WIDTH_DEF,
  parameter int MAX_EDGE      = gaod_pkg::MAX_EDGE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [gaod_pkg::ALPHA_W-1:0]    s_axis_tdata_i,  // [7:0] source_alpha
  input  logic                            s_axis_tuser_i,  // [0] start_of_image
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [gaod_pkg::PIXEL_W-1:0]    m_axis_tdata_o,  // [31:0] outlined_pixel
  input  logic                            cfg_we_i,
  input  logic [gaod_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gaod_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import gaod_pkg::*;

  localparam int COL_W     = $clog2(MAX_ROW_WIDTH);
  localparam int E_W       = $clog2(MAX_EDGE + 1);
  localparam int RING_ROWS = 2 * MAX_EDGE + 1;
  localparam int SLOT_W    = $clog2(RING_ROWS);
  localparam int RAM_DEPTH = RING_ROWS * (2 ** COL_W);
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // Configuration, held in effective (clamped) form
  logic [E_W-1:0]   edge_q, edge_d;
  logic [COL_W-1:0] row_last_q, row_last_d;

  // Position counters
  logic [COL_W-1:0]  col_q, col_d;
  logic [SLOT_W-1:0] rows_q, rows_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  // Stage 1: word accepted, RAM reads in flight
  logic               s1_valid_q;
  logic [ALPHA_W-1:0] s1_alpha_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [SLOT_W-1:0]  s1_rows_q;

  // Output register
  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_data_q, out_data_d;

  logic advance, in_acc, push;

  // Advance whenever the output register is free or being emptied
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && advance;
  assign push            = advance && s1_valid_q;
  assign s_axis_tready_o = advance;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_comb begin
    edge_d     = edge_q;
    row_last_d = row_last_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_EDGE_SIZE: begin
          // Clamp an oversize edge to the ring's limit
          if (32'(cfg_wdata_i[EDGE_CFG_W-1:0]) > 32'(MAX_EDGE)) begin
            edge_d = E_W'(MAX_EDGE);
          end else begin
            edge_d = E_W'(cfg_wdata_i[EDGE_CFG_W-1:0]);
          end
        end
        REG_ROW_WIDTH: begin
          // Store the last column; zero width acts as one
          if (cfg_wdata_i == '0) begin
            row_last_d = '0;
          end else if (32'(cfg_wdata_i) > 32'(MAX_ROW_WIDTH)) begin
            row_last_d = COL_W'(MAX_ROW_WIDTH - 1);
          end else begin
            row_last_d = COL_W'(32'(cfg_wdata_i) - 32'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Position of the incoming word and ring addressing
  // ---------------------------------------------------------------------
  logic [COL_W-1:0]  cur_col;
  logic [SLOT_W-1:0] cur_rows, cur_slot;
  logic [SLOT_W-1:0] edge_s, twice_edge_s;
  logic [SLOT_W-1:0] near_slot, far_slot;
  logic [ADDR_W-1:0] waddr, near_raddr, far_raddr;

  assign edge_s       = SLOT_W'(edge_q);
  assign twice_edge_s = SLOT_W'(edge_s << 1);

  // A start mark makes this word position (0,0)
  assign cur_col  = s_axis_tuser_i ? '0 : col_q;
  assign cur_rows = s_axis_tuser_i ? '0 : rows_q;
  assign cur_slot = s_axis_tuser_i ? '0 : slot_q;

  // Ring of 2e+1 rows: step back e or 2e slots with wrap
  assign near_slot = (cur_slot >= edge_s) ? SLOT_W'(cur_slot - edge_s)
                                          : SLOT_W'(cur_slot + edge_s + 1'b1);
  assign far_slot  = (cur_slot >= twice_edge_s) ? SLOT_W'(cur_slot - twice_edge_s)
                                                : SLOT_W'(cur_slot + 1'b1);

  assign waddr      = ADDR_W'({cur_slot, cur_col});
  assign near_raddr = ADDR_W'({near_slot, cur_col});
  assign far_raddr  = ADDR_W'({far_slot, cur_col});

  always_comb begin
    col_d  = col_q;
    rows_d = rows_q;
    slot_d = slot_q;
    if (cfg_we_i) begin
      // Any register write restarts the image
      col_d  = '0;
      rows_d = '0;
      slot_d = '0;
    end else if (in_acc) begin
      if (cur_col == row_last_q) begin
        col_d  = '0;
        rows_d = (cur_rows < twice_edge_s) ? SLOT_W'(cur_rows + 1'b1) : cur_rows;
        slot_d = (cur_slot == twice_edge_s) ? '0 : SLOT_W'(cur_slot + 1'b1);
      end else begin
        col_d  = COL_W'(cur_col + 1'b1);
        rows_d = cur_rows;
        slot_d = cur_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q      <= '0;
      row_last_q  <= '0;
      col_q       <= '0;
      rows_q      <= '0;
      slot_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      edge_q     <= edge_d;
      row_last_q <= row_last_d;
      col_q      <= col_d;
      rows_q     <= rows_d;
      slot_q     <= slot_d;
      if (advance) begin
        s1_valid_q  <= in_acc;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_alpha_q <= s_axis_tdata_i;
      s1_col_q   <= cur_col;
      s1_rows_q  <= cur_rows;
    end
    if (push) begin
      out_data_q <= out_data_d;
    end
  end

  // ---------------------------------------------------------------------
  // Row store: two mirrored copies, one read port each
  // ---------------------------------------------------------------------
  logic [ALPHA_W-1:0] near_rdata, far_rdata;

  gaod_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram_near (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (in_acc),
    .raddr_i (near_raddr),
    .rdata_o (near_rdata)
  );

  gaod_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram_far (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (in_acc),
    .raddr_i (far_raddr),
    .rdata_o (far_rdata)
  );

  // ---------------------------------------------------------------------
  // Column offsets: delay lines of length e, advanced once per word
  // ---------------------------------------------------------------------
  logic [ALPHA_W-1:0] near_word, far_word;
  logic [ALPHA_W-1:0] near_e, near_2e, cur_e, far_e;

  // With zero edge every neighbour is the word itself
  assign near_word = (edge_q == '0) ? s1_alpha_q : near_rdata;
  assign far_word  = (edge_q == '0) ? s1_alpha_q : far_rdata;

  gaod_delay #(.DEPTH(MAX_EDGE), .WIDTH(ALPHA_W)) u_dly_near (
    .clk_i (clk_i), .en_i (push), .len_i (edge_q), .din_i (near_word), .dout_o (near_e)
  );

  gaod_delay #(.DEPTH(MAX_EDGE), .WIDTH(ALPHA_W)) u_dly_near2 (
    .clk_i (clk_i), .en_i (push), .len_i (edge_q), .din_i (near_e), .dout_o (near_2e)
  );

  gaod_delay #(.DEPTH(MAX_EDGE), .WIDTH(ALPHA_W)) u_dly_cur (
    .clk_i (clk_i), .en_i (push), .len_i (edge_q), .din_i (s1_alpha_q), .dout_o (cur_e)
  );

  gaod_delay #(.DEPTH(MAX_EDGE), .WIDTH(ALPHA_W)) u_dly_far (
    .clk_i (clk_i), .en_i (push), .len_i (edge_q), .din_i (far_word), .dout_o (far_e)
  );

  // ---------------------------------------------------------------------
  // Masking, max and pixel assembly
  // ---------------------------------------------------------------------
  logic               col_e_ok, col_2e_ok, row_e_ok, row_2e_ok;
  logic [ALPHA_W-1:0] body, cand_left, cand_up, cand_right, cand_top;
  logic [ALPHA_W-1:0] max_a, max_b, outline;

  // A neighbour off the left edge or above the image start reads zero
  assign col_e_ok  = 32'(edge_q) <= 32'(s1_col_q);
  assign col_2e_ok = 32'(twice_edge_s) <= 32'(s1_col_q);
  assign row_e_ok  = 32'(edge_q) <= 32'(s1_rows_q);
  assign row_2e_ok = 32'(twice_edge_s) <= 32'(s1_rows_q);

  assign body       = (col_e_ok && row_e_ok)  ? near_e    : '0;
  assign cand_left  = col_e_ok                ? cur_e     : '0;
  assign cand_top   = (col_e_ok && row_2e_ok) ? far_e     : '0;
  assign cand_up    = row_e_ok                ? near_word : '0;
  assign cand_right = (col_2e_ok && row_e_ok) ? near_2e   : '0;

  assign max_a   = (cand_left > cand_top) ? cand_left : cand_top;
  assign max_b   = (cand_up > cand_right) ? cand_up : cand_right;
  assign outline = (max_a > max_b) ? max_a : max_b;

  assign out_data_d = {outline | body, body, body, body};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### hdl/gaod_checker.sv
// Port-level checker for the glyph outline block, bound to the top level
`include "glyph_alpha_outline_dilation_assert.svh"

module gaod_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [gaod_pkg::PIXEL_W-1:0] m_axis_tdata_o
);
  import gaod_pkg::*;

  logic                 out_stall, in_take;
  logic [ALPHA_W-1:0]   top_byte, body_byte;
  logic [2*ALPHA_W-1:0] mid_bytes;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_take   = s_axis_tvalid_i && s_axis_tready_o;
  assign top_byte  = m_axis_tdata_o[31:24];
  assign mid_bytes = m_axis_tdata_o[23:8];
  assign body_byte = m_axis_tdata_o[7:0];

  // Hold the output word while the receiver stalls
  `GAOD_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stall lost word")

  // Lower three bytes all carry the body alpha
  `GAOD_ASSERT(a_body_bytes, m_axis_tvalid_o |-> (mid_bytes == {body_byte, body_byte}), "body bytes differ")

  // Top byte includes every body bit
  `GAOD_ASSERT(a_top_covers_body, m_axis_tvalid_o |-> ((top_byte & body_byte) == body_byte), "top misses body")

  // An accepted word reaches the output through the stage 1 register when not stalled
  `GAOD_ASSERT(a_latency, in_take ##1 m_axis_tready_i |=> m_axis_tvalid_o, "accepted word not delivered")

  // No output word right after reset
  `GAOD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "output valid after reset")

endmodule

bind glyph_alpha_outline_dilation gaod_checker u_gaod_checker (.*);
